@@ rtl/snd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snd_pkg - shared types and constants of the sigmoid neuron
// Widths, register codes, lane control bundle and the tanh table generator.
// ----------------------------------------------------------------------------
package snd_pkg;

	localparam int NUM_INPUTS_DEF  = 5;
	localparam int TANH_DEPTH_DEF  = 256;

	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = 32;
	localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
	localparam int G_W      = 36;
	localparam int DWP_W    = G_W + SAMPLE_W;
	localparam int ACT_W    = 16;
	localparam int SLOPE_W  = 16;
	localparam int SQ_W     = 24;
	localparam int TAG_W    = 8;
	localparam int E_W      = 19;
	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_STEEPNESS     = 8'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LEARNING_RATE = 8'd1;

	localparam logic [15:0] STEEPNESS_RST     = 16'd2048;
	localparam logic [15:0] LEARNING_RATE_RST = 16'd2048;

	typedef struct packed {
		logic load;
		logic mul;
		logic dw;
		logic upd;
	} lane_ctrl_t;

	// bit-serial unsigned divide, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// tanh(8*idx/depth) in Q1.14 from exp(-16/depth) powers
	function automatic logic [15:0] tanh_entry(input int depth, input int idx);
		logic [63:0] a, term, pos, neg, q, t, num, den, r;
		a    = udiv64(64'd16 << 31, 64'(depth));
		term = 64'd1 << 31;
		pos  = 64'd1 << 31;
		neg  = '0;
		for (int n = 1; n <= 24; n++) begin
			term = (term * a + (64'd1 << 30)) >> 31;
			term = udiv64(term + 64'(n / 2), 64'(n));
			if (n % 2 == 1) neg = neg + term;
			else pos = pos + term;
		end
		q = (pos > neg) ? pos - neg : 64'd0;
		t = 64'd1 << 31;
		for (int i = 0; i < idx; i++) begin
			t = (t * q + (64'd1 << 30)) >> 31;
		end
		num = ((64'd1 << 31) - t) << 14;
		den = (64'd1 << 31) + t;
		r   = udiv64(num * 64'd2 + den, den * 64'd2);
		return r[15:0];
	endfunction

endpackage

@@ rtl/sigmoid_neuron_delta_rule.sv @@
`timescale 1ns / 1ps
// a request passes the lane multiply, the serial sum of lane products, the ten-stage
// activation pipeline and, with learn set, the weight update states before its result
// is registered for output; one item in work at a time, another request is taken
// only once the result is in the output register. the output register lets
// a new request in while a result waits. arst_n clears weights, loads both regs to 2048.
// ----------------------------------------------------------------------------
// sigmoid_neuron_delta_rule - bipolar sigmoid neuron with delta rule training
// Parallel weight lanes, serial product merge, tanh activation and update.
// ----------------------------------------------------------------------------
module sigmoid_neuron_delta_rule
	import snd_pkg::*;
#(
	parameter int NUM_INPUTS       = NUM_INPUTS_DEF,
	parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF
)(
	input  logic clk,
	input  logic arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// sample_0 .. sample_(N-1), target, tag
	input  logic [NUM_INPUTS*SAMPLE_W+SAMPLE_W+TAG_W-1:0] s_tdata,
	// learn
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// activation, slope, sq_error, tag_out
	output logic [ACT_W+SLOPE_W+SQ_W+TAG_W-1:0] m_tdata,
	// weight_clipped
	output logic                            m_tuser,
	input  logic                            cfg_we,
	input  logic [CFG_ADDR_W-1:0]           cfg_addr,
	input  logic [CFG_DATA_W-1:0]           cfg_wdata
);

	localparam int SUM_W = PROD_W + $clog2(NUM_INPUTS) + 1;
	localparam int TGT_LSB = NUM_INPUTS * SAMPLE_W;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_SUM  = 7'b0000100,
		ST_ACT  = 7'b0001000,
		ST_DW   = 7'b0010000,
		ST_UPD  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CFG_DATA_W-1:0] steep_q, eta_q;
	logic signed [SAMPLE_W-1:0] target_q;
	logic [TAG_W-1:0] tag_q;
	logic learn_q, clip_q;
	logic out_vld_q;
	logic [ACT_W+SLOPE_W+SQ_W+TAG_W-1:0] out_data_q;
	logic out_clip_q;

	lane_ctrl_t ctrl;
	logic signed [PROD_W-1:0] prod [NUM_INPUTS];
	logic [NUM_INPUTS-1:0] lane_clip;
	logic signed [SUM_W-1:0] sum;
	logic merge_done, act_done, in_req, out_free;
	logic signed [ACT_W-1:0] activation;
	logic [SLOPE_W-1:0] slope;
	logic [SQ_W-1:0] sq_error;
	logic signed [G_W-1:0] grad;

	assign s_tready = (state_q == ST_IDLE);
	assign in_req   = s_tvalid & s_tready;
	assign out_free = ~out_vld_q | m_tready;

	assign ctrl.load = in_req;
	assign ctrl.mul  = (state_q == ST_MUL);
	assign ctrl.dw   = (state_q == ST_DW);
	assign ctrl.upd  = (state_q == ST_UPD);

	for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_lane
		snd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.sample (s_tdata[i*SAMPLE_W +: SAMPLE_W]),
			.grad   (grad),
			.prod   (prod[i]),
			.clip   (lane_clip[i])
		);
	end

	snd_merge #(
		.NUM_INPUTS (NUM_INPUTS),
		.SUM_W      (SUM_W)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.mul),
		.prod   (prod),
		.sum    (sum),
		.done   (merge_done)
	);

	snd_act #(
		.TANH_TABLE_DEPTH (TANH_TABLE_DEPTH),
		.SUM_W            (SUM_W)
	) u_act (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (merge_done),
		.sum           (sum),
		.target        (target_q),
		.steepness     (steep_q),
		.learning_rate (eta_q),
		.activation    (activation),
		.slope         (slope),
		.sq_error      (sq_error),
		.grad          (grad),
		.done          (act_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steep_q <= STEEPNESS_RST;
			eta_q   <= LEARNING_RATE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_STEEPNESS:     steep_q <= cfg_wdata;
				REG_LEARNING_RATE: eta_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_req) begin
			target_q <= s_tdata[TGT_LSB +: SAMPLE_W];
			tag_q    <= s_tdata[TGT_LSB+SAMPLE_W +: TAG_W];
		end
		if (state_q == ST_OUT && out_free) begin
			out_data_q <= {tag_q, sq_error, slope, activation};
			out_clip_q <= clip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			learn_q   <= 1'b0;
			clip_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_req) begin
					learn_q <= s_tuser;
					clip_q  <= 1'b0;
					state_q <= ST_MUL;
				end
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM:  if (merge_done) state_q <= ST_ACT;
				ST_ACT:  if (act_done) state_q <= learn_q ? ST_DW : ST_OUT;
				ST_DW:   state_q <= ST_UPD;
				ST_UPD: begin
					clip_q  <= |lane_clip;
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_free) begin
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_clip_q;

`ifndef SYNTHESIS
	a_req_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_req |=> state_q == ST_MUL)
		else $error("request did not start the lanes");
	a_act_done: assert property (@(posedge clk) disable iff (!arst_n)
		act_done |-> state_q == ST_ACT)
		else $error("activation finished outside its wait state");
	a_no_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !learn_q) |-> !clip_q)
		else $error("clip flag set on a forward pass");
	a_merge: assert property (@(posedge clk) disable iff (!arst_n)
		merge_done |-> state_q == ST_SUM)
		else $error("merge finished outside its wait state");
`endif

endmodule

@@ rtl/snd_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snd_lane - one weight lane
// Holds a weight and a sample, forms x*w and the saturating delta update.
// ----------------------------------------------------------------------------
module snd_lane
	import snd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  lane_ctrl_t                 ctrl,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic signed [G_W-1:0]      grad,
	output logic signed [PROD_W-1:0]   prod,
	output logic                       clip
);

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [WEIGHT_W-1:0] w_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [DWP_W-1:0]    dwp_q;
	logic signed [G_W-1:0]      dw;
	logic signed [WEIGHT_W+4:0] nw;
	logic signed [DWP_W-1:0]    dwp_rnd;
	logic signed [WEIGHT_W-1:0] w_sat;

	always_ff @(posedge clk) begin
		if (ctrl.load) x_q <= sample;
		if (ctrl.mul) prod_q <= x_q * w_q;
		if (ctrl.dw) dwp_q <= grad * x_q;
	end

	// round half away from zero, then drop 16 fraction bits
	always_comb begin
		dwp_rnd = dwp_q + DWP_W'(signed'(33'sh8000)) - DWP_W'(dwp_q[DWP_W-1]);
		dw      = G_W'(dwp_rnd >>> 16);
		nw      = (WEIGHT_W+5)'(w_q) + (WEIGHT_W+5)'(dw);
		clip    = 1'b0;
		w_sat   = nw[WEIGHT_W-1:0];
		if (nw > (WEIGHT_W+5)'(signed'({1'b0, {(WEIGHT_W-1){1'b1}}}))) begin
			w_sat = {1'b0, {(WEIGHT_W-1){1'b1}}};
			clip  = 1'b1;
		end else if (nw < -(WEIGHT_W+5)'(signed'({1'b0, 1'b1, {(WEIGHT_W-1){1'b0}}}))) begin
			w_sat = {1'b1, {(WEIGHT_W-1){1'b0}}};
			clip  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else if (ctrl.upd) begin
			w_q <= w_sat;
		end
	end

	assign prod = prod_q;

endmodule

@@ rtl/snd_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snd_merge - lane product accumulator
// Adds the lane products one per cycle into the dot product.
// ----------------------------------------------------------------------------
module snd_merge
	import snd_pkg::*;
#(
	parameter int NUM_INPUTS = NUM_INPUTS_DEF,
	parameter int SUM_W      = PROD_W + $clog2(NUM_INPUTS) + 1
)(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [PROD_W-1:0] prod [NUM_INPUTS],
	output logic signed [SUM_W-1:0]  sum,
	output logic                     done
);

	localparam int CNT_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_INPUTS - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [SUM_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q & ~start & (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) acc_q <= '0;
		else if (busy_q) acc_q <= acc_q + SUM_W'(prod[cnt_q]);
	end

	assign sum  = acc_q;
	assign done = done_q;

endmodule

@@ rtl/snd_act.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snd_act - activation, slope, error and gradient pipeline
// Table-interpolated tanh of beta*s/2, slope, squared error and eta*e*slope.
// ----------------------------------------------------------------------------
module snd_act
	import snd_pkg::*;
#(
	parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF,
	parameter int SUM_W            = PROD_W + 4
)(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SUM_W-1:0]    sum,
	input  logic signed [SAMPLE_W-1:0] target,
	input  logic [CFG_DATA_W-1:0]      steepness,
	input  logic [CFG_DATA_W-1:0]      learning_rate,
	output logic signed [ACT_W-1:0]    activation,
	output logic [SLOPE_W-1:0]         slope,
	output logic [SQ_W-1:0]            sq_error,
	output logic signed [G_W-1:0]      grad,
	output logic                       done
);

	localparam int NSTG  = 10;
	localparam int IDX_W = $clog2(TANH_TABLE_DEPTH + 1);
	localparam int P_W   = 31 + IDX_W;
	localparam int U_W   = SUM_W - 12 + 16;

	logic [15:0] tab [0:TANH_TABLE_DEPTH];
	for (genvar i = 0; i <= TANH_TABLE_DEPTH; i++) begin : g_tab
		localparam logic [15:0] ENTRY = tanh_entry(TANH_TABLE_DEPTH, i);
		assign tab[i] = ENTRY;
	end

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] neg_q;

	logic [SUM_W-1:0]         mag_s1;
	logic [U_W-1:0]           u_s2;
	logic                     sat_s3;
	logic [IDX_W-1:0]         idx_s3;
	logic [27:0]              fr_s3;
	logic                     sat_s4;
	logic [15:0]              lo_s4, hi_s4;
	logic [27:0]              fr_s4;
	logic signed [ACT_W-1:0]  y_s5;
	logic signed [E_W-1:0]    e_s6;
	logic [28:0]              ysq_s6;
	logic [36:0]              esq_s7;
	logic signed [35:0]       etae_s7;
	logic [28:0]              omy_s7;
	logic [SLOPE_W-1:0]       slope_s8;
	logic [SQ_W-1:0]          sq_s8;
	logic signed [35:0]       etae_s8;
	logic signed [52:0]       m2_s9;
	logic signed [G_W-1:0]    g_s10;

	logic [U_W-1:0]   u_c;
	logic [P_W-1:0]   p_c;
	logic [15:0]      diff_c;
	logic [43:0]      ip_c;
	logic [16:0]      ya_c;
	logic [44:0]      sl_c;
	logic [37:0]      sq_c;
	logic signed [31:0] ysq_c;
	logic signed [37:0] esq_c;
	logic signed [53:0] m2r_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[NSTG-2:0], start};
		end
	end

	always_comb begin
		u_c    = U_W'((U_W'(mag_s1 >> 12) * U_W'(steepness)) >> 1);
		p_c    = (P_W'(u_s2[30:0]) * P_W'(TANH_TABLE_DEPTH)) >> 3;
		diff_c = (hi_s4 > lo_s4) ? hi_s4 - lo_s4 : 16'd0;
		ip_c   = (44'(diff_c) * 44'(fr_s4) + 44'h800_0000) >> 28;
		ya_c   = 17'(lo_s4) + 17'(ip_c);
		if (ya_c > 17'd16384 || sat_s4) ya_c = 17'd16384;
		ysq_c  = 32'(y_s5) * 32'(y_s5);
		esq_c  = 38'(e_s6) * 38'(e_s6);
		sl_c   = (45'(steepness) * 45'(omy_s7) + 45'h800_0000) >> 28;
		sq_c   = (38'(esq_s7) + 38'd4096) >> 13;
		m2r_c  = 54'(m2_s9) + 54'sh2_0000 - 54'(m2_s9[52]);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_s1   <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
			neg_q[0] <= sum[SUM_W-1];
		end
		for (int k = 1; k < NSTG; k++) begin
			if (vld_q[k-1]) neg_q[k] <= neg_q[k-1];
		end
		if (vld_q[0]) u_s2 <= u_c;
		if (vld_q[1]) begin
			sat_s3 <= (u_s2 >= U_W'(64'd1 << 31));
			idx_s3 <= p_c[28 +: IDX_W];
			fr_s3  <= p_c[27:0];
		end
		if (vld_q[2]) begin
			sat_s4 <= sat_s3;
			lo_s4  <= tab[idx_s3];
			hi_s4  <= tab[idx_s3 + 1'b1];
			fr_s4  <= fr_s3;
		end
		if (vld_q[3]) y_s5 <= neg_q[3] ? -ACT_W'(ya_c) : ACT_W'(ya_c);
		if (vld_q[4]) begin
			e_s6   <= E_W'(signed'({target, 2'b00})) - E_W'(y_s5);
			ysq_s6 <= ysq_c[28:0];
		end
		if (vld_q[5]) begin
			esq_s7  <= esq_c[36:0];
			etae_s7 <= $signed({1'b0, learning_rate}) * e_s6;
			omy_s7  <= 29'h1000_0000 - ysq_s6;
		end
		if (vld_q[6]) begin
			slope_s8 <= (sl_c > 45'hFFFF) ? '1 : sl_c[SLOPE_W-1:0];
			sq_s8    <= (sq_c > 38'hFF_FFFF) ? '1 : sq_c[SQ_W-1:0];
			etae_s8  <= etae_s7;
		end
		if (vld_q[7]) m2_s9 <= etae_s8 * $signed({1'b0, slope_s8});
		if (vld_q[8]) g_s10 <= G_W'(m2r_c >>> 18);
	end

	assign activation = y_s5;
	assign slope      = slope_s8;
	assign sq_error   = sq_s8;
	assign grad       = g_s10;
	assign done       = vld_q[NSTG-1] & neg_q[NSTG-1] | vld_q[NSTG-1] & ~neg_q[NSTG-1];

endmodule

@@ dv/neuron_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neuron_result_checker - predicts and checks the sigmoid neuron results
// Watches the request, result and register write ports, keeps its own copy of
// weights and registers, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module neuron_result_checker
	import snd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,
	input  logic         m_tuser,
	input  logic         cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int           pending,
	output int           errors
);

	localparam int N_IN  = 5;
	localparam int DEPTH = 256;
	localparam longint ONE28 = 64'sd1 <<< 28;

	typedef struct packed {
		logic [15:0] activation;
		logic [15:0] slope;
		logic [23:0] sq_error;
		logic [7:0]  tag;
		logic        clipped;
	} neuron_result_t;

	neuron_result_t predicted_outputs[$];
	longint         weight_q16[N_IN];
	longint         beta_q12;
	longint         eta_q12;
	longint unsigned tanh_q14[DEPTH+1];

	// tanh(8*i/DEPTH) from powers of exp(-16/DEPTH) by series
	initial begin
		longint unsigned a, term, sum_pos, sum_neg, ratio, t, num, den;
		a       = (64'd16 << 31) / DEPTH;
		term    = 64'd1 << 31;
		sum_pos = 64'd1 << 31;
		sum_neg = 0;
		for (int n = 1; n <= 24; n++) begin
			term = (term * a + (64'd1 << 30)) >> 31;
			term = (term + n / 2) / n;
			if (n % 2 == 1) sum_neg += term;
			else sum_pos += term;
		end
		ratio = sum_pos > sum_neg ? sum_pos - sum_neg : 0;
		t = 64'd1 << 31;
		for (int i = 0; i <= DEPTH; i++) begin
			num = ((64'd1 << 31) - t) << 14;
			den = (64'd1 << 31) + t;
			tanh_q14[i] = (num * 2 + den) / (den * 2);
			t = (t * ratio + (64'd1 << 30)) >> 31;
		end
	end

	// shift right rounding half away from zero
	function automatic longint round_shift(longint v, int n);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + (64'sd1 <<< (n - 1))) >>> n;
		return v < 0 ? -m : m;
	endfunction

	function automatic neuron_result_t neuron_forward_update(logic [103:0] data, logic learn);
		neuron_result_t r;
		longint x[N_IN];
		longint acc, mag, u, p, idx, fr, lo, hi, diff, ya, y, slp, d, e, sq, g, nw;
		acc = 0;
		r.clipped = 1'b0;
		for (int i = 0; i < N_IN; i++) begin
			x[i] = longint'($signed(data[16*i +: 16]));
			acc += x[i] * weight_q16[i];
		end
		mag = acc < 0 ? -acc : acc;
		u = ((mag >>> 12) * beta_q12) >>> 1;
		if (u >= (64'sd1 <<< 31)) begin
			ya = 16384;
		end else begin
			p   = (u * DEPTH) >>> 3;
			idx = p >>> 28;
			fr  = p & (ONE28 - 1);
			if (idx >= DEPTH) idx = DEPTH - 1;
			lo   = longint'(tanh_q14[idx]);
			hi   = longint'(tanh_q14[idx + 1]);
			diff = hi > lo ? hi - lo : 0;
			ya   = lo + ((diff * fr + (ONE28 >>> 1)) >>> 28);
			if (ya > 16384) ya = 16384;
		end
		y = acc < 0 ? -ya : ya;
		slp = (beta_q12 * (ONE28 - y * y) + (ONE28 >>> 1)) >>> 28;
		if (slp > 65535) slp = 65535;
		d  = longint'($signed(data[95:80])) * 4;
		e  = d - y;
		sq = (e * e + 4096) >>> 13;
		if (sq > 64'sh_FF_FFFF) sq = 64'sh_FF_FFFF;
		if (learn) begin
			g = round_shift(eta_q12 * e * slp, 18);
			for (int i = 0; i < N_IN; i++) begin
				nw = weight_q16[i] + round_shift(g * x[i], 16);
				if (nw > 64'sd2147483647) begin
					nw = 64'sd2147483647;
					r.clipped = 1'b1;
				end
				if (nw < -64'sd2147483648) begin
					nw = -64'sd2147483648;
					r.clipped = 1'b1;
				end
				weight_q16[i] = nw;
			end
		end
		r.activation = y[15:0];
		r.slope      = slp[15:0];
		r.sq_error   = sq[23:0];
		r.tag        = data[103:96];
		return r;
	endfunction

	assign pending = predicted_outputs.size();

	always @(posedge clk or negedge arst_n) begin
		neuron_result_t exp_r, got;
		if (!arst_n) begin
			predicted_outputs.delete();
			for (int i = 0; i < N_IN; i++) weight_q16[i] = 0;
			beta_q12 = STEEPNESS_RST;
			eta_q12  = LEARNING_RATE_RST;
			errors   = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[15:0], m_tdata[31:16], m_tdata[55:32], m_tdata[63:56],
					m_tuser};
				if (predicted_outputs.size() == 0) begin
					$display("%0t: result with no request pending: %h", $time, got);
					errors++;
				end else begin
					exp_r = predicted_outputs.pop_front();
					if (got.activation !== exp_r.activation) begin
						$display("%0t: activation expected %h actual %h", $time,
							exp_r.activation, got.activation);
						errors++;
					end
					if (got.slope !== exp_r.slope) begin
						$display("%0t: slope expected %h actual %h", $time,
							exp_r.slope, got.slope);
						errors++;
					end
					if (got.sq_error !== exp_r.sq_error) begin
						$display("%0t: sq_error expected %h actual %h", $time,
							exp_r.sq_error, got.sq_error);
						errors++;
					end
					if (got.tag !== exp_r.tag) begin
						$display("%0t: tag expected %h actual %h", $time,
							exp_r.tag, got.tag);
						errors++;
					end
					if (got.clipped !== exp_r.clipped) begin
						$display("%0t: weight_clipped expected %b actual %b", $time,
							exp_r.clipped, got.clipped);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predicted_outputs.push_back(neuron_forward_update(s_tdata, s_tuser));
			if (cfg_we) begin
				if (cfg_addr == REG_STEEPNESS) beta_q12 = cfg_wdata;
				else if (cfg_addr == REG_LEARNING_RATE) eta_q12 = cfg_wdata;
			end
		end
	end

endmodule

@@ dv/tb_sigmoid_neuron_delta_rule.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sigmoid_neuron_delta_rule - stimulus and verdict for the sigmoid neuron
// Directed corner requests, then random training phases under several
// steepness and learning rate settings, with bursty requests and stalls.
// ----------------------------------------------------------------------------
module tb_sigmoid_neuron_delta_rule;
	import snd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid, s_tready, s_tuser;
	logic [103:0] s_tdata;
	logic         m_tvalid, m_tready, m_tuser;
	logic [63:0]  m_tdata;
	logic         cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int           pending, errors, cycles;
	int           burst_left;
	int           hold_asked, hold_seen;

	sigmoid_neuron_delta_rule dut (.*);

	neuron_result_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_sigmoid_neuron_delta_rule: errors");
			$finish;
		end
	end

	// receiver: random stall modes, long hold on request
	initial begin
		int mode;
		m_tready  = 1'b0;
		hold_seen = 0;
		mode      = 0;
		forever begin
			@(negedge clk);
			if (hold_asked != hold_seen) begin
				hold_seen = hold_asked;
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
			end else begin
				if (cycles % 64 == 0) mode = $urandom_range(0, 3);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= ($urandom_range(0, 9) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3, 4, 5, 6: return 16'($signed($urandom_range(0, 8192)) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [103:0] random_request();
		logic [103:0] d;
		for (int i = 0; i < 5; i++) d[16*i +: 16] = pick_sample();
		d[95:80]  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($signed($urandom_range(0, 8192)) - 4096);
		d[103:96] = 8'($urandom);
		return d;
	endfunction

	task automatic send_request(logic [103:0] data, logic learn);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= learn;
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		logic [103:0] d;
		logic [15:0]  beta_set[6];
		logic [15:0]  eta_set[6];
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		cfg_we     = 1'b0;
		cfg_addr   = '0;
		cfg_wdata  = '0;
		cycles     = 0;
		hold_asked = 0;
		burst_left = 5;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corners under reset settings: zero, extremes, both learn values
		send_request('0, 1'b0);
		send_request({8'hff, 16'h7fff, {5{16'h7fff}}}, 1'b0);
		send_request({8'h00, 16'h8000, {5{16'h8000}}}, 1'b1);
		send_request({8'ha5, 16'h7fff, {5{16'h7fff}}}, 1'b1);
		send_request({8'h5a, 16'h8000, {5{16'h7fff}}}, 1'b1);
		for (int k = 0; k < 10; k++)
			send_request({8'(k), 16'h1000, 16'h1000, {4{16'h7fff}}}, 1'b1);
		send_request({8'h11, 16'h1000, {5{16'h7fff}}}, 1'b0);
		send_request({8'h12, 16'hf000, {5{16'h8000}}}, 1'b0);
		wait_idle();

		// both registers at their maximum drive weights into saturation
		write_reg(REG_STEEPNESS, 16'hffff);
		write_reg(REG_LEARNING_RATE, 16'hffff);
		write_reg(8'd2, 16'h0001);
		write_reg(8'hff, 16'h0000);
		for (int k = 0; k < 6; k++)
			send_request({8'(k), 16'h8000, {5{16'h7fff}}}, 1'b1);
		send_request({8'h20, 16'h7fff, {5{16'h8000}}}, 1'b1);
		wait_idle();

		beta_set = '{16'd0, 16'd2048, 16'hffff, 16'd4096, 16'd1, 16'($urandom)};
		eta_set  = '{16'd0, 16'd2048, 16'hffff, 16'd40, 16'd1, 16'($urandom)};
		for (int ph = 0; ph < 6; ph++) begin
			arst_n = 1'b1;
			write_reg(REG_STEEPNESS, beta_set[ph]);
			write_reg(REG_LEARNING_RATE, eta_set[ph]);
			if (ph == 3) write_reg(8'($urandom_range(2, 255)), 16'($urandom));
			for (int k = 0; k < 180; k++) begin
				if (ph == 2 && k == 50) hold_asked++;
				d = random_request();
				send_request(d, $urandom_range(0, 9) < 7);
			end
			wait_idle();
		end

		if (errors == 0)
			$display("tb_sigmoid_neuron_delta_rule: clean");
		else
			$display("tb_sigmoid_neuron_delta_rule: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/snd_pkg.sv
rtl/snd_lane.sv
rtl/snd_merge.sv
rtl/snd_act.sv
rtl/sigmoid_neuron_delta_rule.sv
dv/neuron_result_checker.sv
dv/tb_sigmoid_neuron_delta_rule.sv
